// File: sv/cro_pkg.sv
package cro_pkg;

    localparam int COST_FIELD_W = 32;
    localparam int FIELD_W      = 6;

    typedef struct packed {
        logic [COST_FIELD_W-1:0] cost;
        logic                    last;
    } in_word_t;

    typedef struct packed {
        logic [FIELD_W-1:0] rank_position;
        logic [FIELD_W-1:0] zone_index;
        logic               overflowed;
        logic               last_result;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_HOLD,
        ST_SCAN,
        ST_WRITE,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic fetch_i;
        logic hold_i;
        logic scan;
        logic rank_wr;
        logic emit_rd;
        logic emit_ld;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic k_end;
        logic i_end;
        logic r_end;
        logic out_free;
    } status_t;

endpackage

// File: sv/cro_ctrl.sv
module cro_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_last,
    output logic             s_ready,
    input  cro_pkg::status_t st,
    output cro_pkg::cmd_t    cmd
);

    cro_pkg::state_t state_reg;
    cro_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cro_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cro_pkg::ST_CLEAR: begin
                if (st.clr_last) begin
                    state_next = cro_pkg::ST_IDLE;
                end
            end
            cro_pkg::ST_IDLE: begin
                if (s_valid && s_last) begin
                    state_next = cro_pkg::ST_FETCH;
                end
            end
            cro_pkg::ST_FETCH: state_next = cro_pkg::ST_HOLD;
            cro_pkg::ST_HOLD:  state_next = cro_pkg::ST_SCAN;
            cro_pkg::ST_SCAN: begin
                if (st.k_end) begin
                    state_next = cro_pkg::ST_WRITE;
                end
            end
            cro_pkg::ST_WRITE: begin
                if (st.i_end) begin
                    state_next = cro_pkg::ST_EMIT_RD;
                end else begin
                    state_next = cro_pkg::ST_FETCH;
                end
            end
            cro_pkg::ST_EMIT_RD: state_next = cro_pkg::ST_EMIT_LD;
            cro_pkg::ST_EMIT_LD: begin
                if (st.out_free) begin
                    state_next = st.r_end ? cro_pkg::ST_IDLE : cro_pkg::ST_EMIT_RD;
                end
            end
            default: state_next = cro_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        case (state_reg)
            cro_pkg::ST_CLEAR:   cmd.clr_step = 1'b1;
            cro_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            cro_pkg::ST_FETCH:   cmd.fetch_i = 1'b1;
            cro_pkg::ST_HOLD:    cmd.hold_i  = 1'b1;
            cro_pkg::ST_SCAN:    cmd.scan    = 1'b1;
            cro_pkg::ST_WRITE:   cmd.rank_wr = 1'b1;
            cro_pkg::ST_EMIT_RD: cmd.emit_rd = 1'b1;
            cro_pkg::ST_EMIT_LD: cmd.emit_ld = 1'b1;
            default: cmd = '0;
        endcase
    end

`ifndef NO_ASSERTIONS
    // The comparison sweep only ends once every stored cost has been seen.
    a_scan_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cro_pkg::ST_SCAN && !st.k_end) |=> state_reg == cro_pkg::ST_SCAN)
        else $error("ranking sweep left early");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cro_pkg::ST_IDLE && s_valid && s_last)
            |=> !s_ready && state_reg == cro_pkg::ST_FETCH)
        else $error("last word did not start ranking");
`endif

endmodule

// File: sv/cro_dp.sv
module cro_dp #(
    parameter int MAX_ZONES  = 64,
    parameter int COST_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cro_pkg::in_word_t  s_data,
    input  logic               m_ready,
    output logic               m_valid,
    output cro_pkg::out_word_t m_data,
    input  cro_pkg::cmd_t      cmd,
    output cro_pkg::status_t   st
);

    localparam int AW      = $clog2(MAX_ZONES);
    localparam int CW      = $clog2(MAX_ZONES + 1);
    localparam int STORE_W = (COST_WIDTH < cro_pkg::COST_FIELD_W) ? COST_WIDTH
                                                                   : cro_pkg::COST_FIELD_W;

    logic [STORE_W-1:0] cost_mem [MAX_ZONES];
    logic [AW-1:0]      order_mem [MAX_ZONES];

    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [AW-1:0]      rank_reg, rank_next;
    logic [AW-1:0]      r_reg, r_next;
    logic [STORE_W-1:0] cost_i_reg, cost_i_next;
    logic [STORE_W-1:0] cost_rd_reg;
    logic [AW-1:0]      ord_rd_reg;
    logic               out_valid_reg, out_valid_next;
    cro_pkg::out_word_t out_reg, out_next;

    logic [AW-1:0]      cost_ra;
    logic               full;
    logic               ord_we;
    logic [AW-1:0]      ord_wa;
    logic [AW-1:0]      ord_wd;
    logic               emit_go;
    logic [AW+5:0]      zone_ext;
    logic [AW+5:0]      pos_ext;

    assign full    = (count_reg == CW'(MAX_ZONES));
    assign emit_go = cmd.emit_ld && st.out_free;

    assign st.clr_last = (clr_reg == AW'(MAX_ZONES - 1));
    assign st.k_end    = (k_reg == count_reg);
    assign st.i_end    = ((CW'(i_reg) + CW'(1)) == count_reg);
    assign st.r_end    = ((CW'(r_reg) + CW'(1)) == count_reg);
    assign st.out_free = !out_valid_reg || m_ready;

    assign zone_ext = {6'd0, ord_rd_reg};
    assign pos_ext  = {6'd0, r_reg};

    always_comb begin
        cost_ra = '0;
        if (cmd.fetch_i) begin
            cost_ra = i_reg;
        end else if (cmd.scan) begin
            cost_ra = k_reg[AW-1:0];
        end
    end

    // Each order entry is zeroed as it is reported, so the store is clean for the next set.
    always_comb begin
        ord_we = 1'b0;
        ord_wa = clr_reg;
        ord_wd = '0;
        if (cmd.clr_step) begin
            ord_we = 1'b1;
        end else if (cmd.rank_wr) begin
            ord_we = 1'b1;
            ord_wa = rank_reg;
            ord_wd = i_reg;
        end else if (emit_go) begin
            ord_we = 1'b1;
            ord_wa = r_reg;
        end
    end

    always_comb begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        clr_next       = clr_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        rank_next      = rank_reg;
        r_next         = r_reg;
        cost_i_next    = cost_i_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;

        if (cmd.clr_step) begin
            clr_next = clr_reg + AW'(1);
        end
        if (cmd.load) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.hold_i) begin
            cost_i_next = cost_rd_reg;
            rank_next   = '0;
            k_next      = CW'(1);
        end
        if (cmd.scan) begin
            k_next = k_reg + CW'(1);
            if (cost_i_reg > cost_rd_reg) begin
                rank_next = rank_reg + AW'(1);
            end
        end
        if (cmd.rank_wr) begin
            i_next = i_reg + AW'(1);
        end
        if (emit_go) begin
            out_valid_next         = 1'b1;
            out_next.rank_position = pos_ext[5:0];
            out_next.zone_index    = zone_ext[5:0];
            out_next.overflowed    = ovf_reg;
            out_next.last_result   = st.r_end;
            if (st.r_end) begin
                count_next = '0;
                ovf_next   = 1'b0;
                i_next     = '0;
                r_next     = '0;
            end else begin
                r_next = r_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            clr_reg       <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            rank_reg      <= '0;
            r_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            clr_reg       <= clr_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            rank_reg      <= rank_next;
            r_reg         <= r_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cost_i_reg <= cost_i_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && !full) begin
            cost_mem[count_reg[AW-1:0]] <= s_data.cost[STORE_W-1:0];
        end
        cost_rd_reg <= cost_mem[cost_ra];
    end

    always_ff @(posedge aclk) begin
        if (ord_we) begin
            order_mem[ord_wa] <= ord_wd;
        end
        if (cmd.emit_rd) begin
            ord_rd_reg <= order_mem[r_reg];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ZONES))
        else $error("zone count beyond capacity");
    a_rank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rank_wr |-> CW'(rank_reg) < count_reg)
        else $error("rank outside the stored set");
    a_set_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_go && st.r_end) |=> (count_reg == '0 && !ovf_reg && r_reg == '0))
        else $error("set state not cleared after final word");
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_go |=> (m_valid && m_data.last_result == $past(st.r_end)))
        else $error("final word flag mismatch");
`endif

endmodule

// File: sv/cost_rank_order_top.sv
// Channel | Ports                       | Word
// input   | s_valid, s_ready, s_data    | cost (32), last (1)
// result  | m_valid, m_ready, m_data    | rank_position (6), zone_index (6),
//         |                             | overflowed (1), last_result (1)
//
// A word that is not last is stored as it is accepted. After the last word the
// block ranks N stored zones with a single comparator over the cost memory read
// port, then reads each result word from the order memory into the output register,
// where it waits on m_ready. After reset the order memory is cleared entry by entry,
// during which s_ready stays low. Reset is synchronous and active low on aclk.
// The final result word may wait in the output register while the next set loads.
module cost_rank_order_top #(
    parameter int MAX_ZONES  = 64,
    parameter int COST_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cro_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cro_pkg::out_word_t m_data
);

    cro_pkg::cmd_t    cmd;
    cro_pkg::status_t st;

    cro_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    cro_dp #(
        .MAX_ZONES  (MAX_ZONES),
        .COST_WIDTH (COST_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .st      (st)
    );

endmodule

// File: sim/cost_rank_order_checker.sv
`timescale 1ns / 1ps

module cost_rank_order_checker #(
    parameter int MAX_ZONES  = 64,
    parameter int COST_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  cro_pkg::in_word_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  cro_pkg::out_word_t m_data,
    output int                 fail_count,
    output int                 words_due
);

    logic [COST_WIDTH-1:0] zone_costs [MAX_ZONES];
    int unsigned           zones_held;
    bit                    zones_dropped;
    cro_pkg::out_word_t    order_words_due [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: error: %s", $time, msg);
        fail_count++;
    endtask

    // Stores one zone and, on the final word of a set, queues the zone order.
    task automatic store_zone(input cro_pkg::in_word_t w);
        int unsigned        n;
        int unsigned        rank;
        int unsigned        zone_at [MAX_ZONES];
        cro_pkg::out_word_t o;
        if (zones_held < MAX_ZONES) begin
            zone_costs[zones_held] = COST_WIDTH'(w.cost);
            zones_held++;
        end else begin
            zones_dropped = 1'b1;
        end
        if (!w.last) return;

        n = zones_held;
        foreach (zone_at[r]) zone_at[r] = 0;
        // Scanning upwards leaves the highest index on a shared rank.
        for (int unsigned i = 0; i < n; i++) begin
            rank = 0;
            for (int unsigned k = 0; k < n; k++) begin
                if (zone_costs[i] > zone_costs[k]) rank++;
            end
            zone_at[rank] = i;
        end
        for (int unsigned r = 0; r < n; r++) begin
            o.rank_position = cro_pkg::FIELD_W'(r);
            o.zone_index    = cro_pkg::FIELD_W'(zone_at[r]);
            o.overflowed    = zones_dropped;
            o.last_result   = (r + 1 == n);
            order_words_due = {order_words_due, o};
        end
        zones_held    = 0;
        zones_dropped = 1'b0;
    endtask

    always @(posedge aclk) begin : watch_channels
        cro_pkg::out_word_t want;
        if (!aresetn) begin
            zones_held    = 0;
            zones_dropped = 1'b0;
            order_words_due.delete();
        end else begin
            if (s_valid && s_ready) store_zone(s_data);
            if (m_valid && m_ready) begin
                if (order_words_due.size() == 0) begin
                    report_mismatch($sformatf("result word %p arrived with none expected",
                                              m_data));
                end else begin
                    want = order_words_due.pop_front();
                    if (m_data.rank_position !== want.rank_position)
                        report_mismatch($sformatf("rank_position expected %0d, got %0d",
                                                  want.rank_position, m_data.rank_position));
                    if (m_data.zone_index !== want.zone_index)
                        report_mismatch($sformatf("zone_index at rank %0d expected %0d, got %0d",
                                                  want.rank_position, want.zone_index,
                                                  m_data.zone_index));
                    if (m_data.overflowed !== want.overflowed)
                        report_mismatch($sformatf("overflowed at rank %0d expected %0b, got %0b",
                                                  want.rank_position, want.overflowed,
                                                  m_data.overflowed));
                    if (m_data.last_result !== want.last_result)
                        report_mismatch($sformatf("last_result at rank %0d expected %0b, got %0b",
                                                  want.rank_position, want.last_result,
                                                  m_data.last_result));
                end
            end
        end
        words_due <= order_words_due.size();
    end

endmodule

// File: sim/cost_rank_order_top_tb.sv
`timescale 1ns / 1ps

module cost_rank_order_top_tb;

    localparam int MAX_ZONES      = 64;
    localparam int COST_WIDTH     = 32;
    localparam int WORD_TARGET    = 470;
    localparam int STALL_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 50;

    typedef enum {SPREAD, FEW_VALUES, NEAR_ZERO, NEAR_TOP} cost_style_t;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    cro_pkg::in_word_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    cro_pkg::out_word_t m_data;

    int fail_count;
    int words_due;
    int send_idle_pct = 34;
    int recv_idle_pct = 49;
    bit stall_request = 1'b0;
    int quiet_cycles  = 0;
    int words_sent    = 0;

    cost_rank_order_top #(
        .MAX_ZONES (MAX_ZONES),
        .COST_WIDTH(COST_WIDTH)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    cost_rank_order_checker #(
        .MAX_ZONES (MAX_ZONES),
        .COST_WIDTH(COST_WIDTH)
    ) order_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .fail_count(fail_count),
        .words_due (words_due)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The long hold-off is timed here so that the sender keeps offering words meanwhile.
    initial begin : receiver
        int held;
        forever begin
            @(posedge aclk);
            if (stall_request) begin
                stall_request = 1'b0;
                m_ready <= 1'b0;
                for (held = 0; held < STALL_CYCLES; held++) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_word(input logic [31:0] cost, input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= '{cost: cost, last: last};
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_set(input logic [31:0] costs [$]);
        foreach (costs[i]) send_word(costs[i], i == costs.size() - 1);
    endtask

    task automatic send_random_set(input int unsigned zones);
        logic [31:0] costs [$];
        logic [31:0] pool [4];
        cost_style_t style;
        style = cost_style_t'($urandom_range(3));
        foreach (pool[p]) pool[p] = $urandom;
        repeat (zones) begin
            case (style)
                SPREAD:     costs = {costs, $urandom};
                FEW_VALUES: costs = {costs, pool[$urandom_range(3)]};
                NEAR_ZERO:  costs = {costs, 32'($urandom_range(7))};
                default:    costs = {costs, 32'hFFFF_FFFF - 32'($urandom_range(7))};
            endcase
        end
        send_set(costs);
    endtask

    // Mostly small sets, since ranking time grows with the square of the set size.
    function automatic int unsigned pick_zone_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 3) return $urandom_range(MAX_ZONES - 4, MAX_ZONES + 6);
        if (roll < 15) return $urandom_range(13, 32);
        return $urandom_range(1, 12);
    endfunction

    task automatic run_random(input int unsigned upto);
        while (words_sent < upto) send_random_set(pick_zone_count());
    endtask

    initial begin : stimulus
        logic [31:0] costs [$];
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        costs = '{32'hFFFF_FFFF};
        send_set(costs);
        costs = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000};
        send_set(costs);
        // All equal: the highest index takes rank 0 and the other positions report zone 0.
        costs = '{32'd7, 32'd7, 32'd7, 32'd7};
        send_set(costs);
        costs = '{32'd5, 32'd3, 32'd5, 32'd3, 32'd9};
        send_set(costs);
        costs = '{32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFE, 32'h1234_5678};
        send_set(costs);
        costs = '{32'hFFFF_FFFF, 32'h0000_0000};
        send_set(costs);

        // A full store, then one where the final word is dropped.
        send_random_set(MAX_ZONES);
        send_random_set(MAX_ZONES + 1);
        run_random(WORD_TARGET / 3);

        send_idle_pct = 49;
        recv_idle_pct = 34;
        send_random_set($urandom_range(MAX_ZONES + 2, MAX_ZONES + 8));
        run_random(2 * WORD_TARGET / 3);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 1'b1;
        run_random(WORD_TARGET);

        s_valid <= 1'b0;
        do @(posedge aclk); while (words_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
